FILE: hw/rtl/refcounted_page_allocator_macros.svh
// assertion macros for the page allocator
// used by the top level only, no other dependencies
`ifndef REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define RPA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rpa assertion failed");

// next-cycle implication
`define RPA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rpa assertion failed");

`endif

FILE: hw/rtl/rpa_pkg.sv
// types and constants shared by the page allocator files
// no dependencies
package rpa_pkg;

	localparam int PAGE_W = 12;
	localparam int FREE_W = 13;
	localparam int CFG_W  = 13;
	localparam int CFG_IDX_W = 1;
	localparam int QDEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUND = 1'b1;

	localparam logic [CFG_W-1:0] TOTAL_RST = 13'd4096;
	localparam logic [CFG_W-1:0] BOUND_RST = 13'd1024;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_ADD     = 2'd2;

	typedef enum logic [1:0] {
		K_ALLOC   = 2'd0,
		K_RELEASE = 2'd1,
		K_ADD     = 2'd2,
		K_NOP     = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_ZERO  = 3'd2,
		ST_RANGE = 3'd3,
		ST_FREE  = 3'd4,
		ST_SAT   = 3'd5
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [PAGE_W-1:0] page;
		logic              high_ok;
		logic              low;
		status_t           pre;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} push_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_out_t;

endpackage

FILE: hw/rtl/rpa_if.sv
// request and result channel interfaces of the page allocator
// depends on rpa_pkg
interface rpa_req_if import rpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [PAGE_W-1:0] page_number;
	logic              high_allowed;

	modport source (output valid, req_type, page_number, high_allowed, input ready);
	modport sink (input valid, req_type, page_number, high_allowed, output ready);
endinterface

interface rpa_rsp_if import rpa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] granted_page;
	logic [2:0]        status;
	logic [FREE_W-1:0] low_free;
	logic [FREE_W-1:0] high_free;

	modport source (output valid, granted_page, status, low_free, high_free, input ready);
	modport sink (input valid, granted_page, status, low_free, high_free, output ready);
endinterface

FILE: hw/rtl/rpa_front.sv
// front end: takes requests, checks page range and pool side
// depends on rpa_pkg and rpa_req_if
module rpa_front import rpa_pkg::*; #(
	parameter int PAGES = 4096
) (
	rpa_req_if.sink          req,
	input  logic             clearing,
	input  logic             q_full,
	input  logic [CFG_W-1:0] page_total,
	input  logic [CFG_W-1:0] low_bound,
	output push_t            push
);

	logic    in_range;
	logic    is_zero;
	kind_t   kind;
	status_t pre;

	assign req.ready = !clearing && !q_full;
	assign is_zero   = req.page_number == '0;
	assign in_range  = ({1'b0, req.page_number} < page_total)
		&& (32'(req.page_number) < 32'(PAGES));

	always_comb begin
		kind = K_NOP;
		pre  = ST_OK;
		unique case (req.req_type)
			REQ_ALLOC: begin
				kind = K_ALLOC;
			end
			REQ_RELEASE: begin
				kind = K_RELEASE;
				if (is_zero)
					pre = ST_ZERO;
				else if (!in_range)
					pre = ST_RANGE;
			end
			REQ_ADD: begin
				kind = K_ADD;
				if (!in_range)
					pre = ST_RANGE;
			end
			default: begin
				kind = K_NOP;
			end
		endcase
	end

	assign push.valid       = req.valid && req.ready;
	assign push.cmd.kind    = kind;
	assign push.cmd.page    = req.page_number;
	assign push.cmd.high_ok = req.high_allowed;
	assign push.cmd.low     = {1'b0, req.page_number} < low_bound;
	assign push.cmd.pre     = pre;

endmodule

FILE: hw/rtl/rpa_queue.sv
// two-entry request queue between front and back
// depends on rpa_pkg
module rpa_queue import rpa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output logic   full,
	output q_out_t head
);

	localparam int PW = $clog2(QDEPTH);

	cmd_t          entries_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full       = count_q == (PW+1)'(QDEPTH);
	assign head.valid = count_q != '0;
	assign head.cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid)
			entries_q[wr_ptr_q] <= push.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push.valid && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push.valid)
				count_q <= count_q - (PW+1)'(1);
		end
	end

endmodule

FILE: hw/rtl/rpa_back.sv
// back end: count memory, both free stacks and the result register
// depends on rpa_pkg and rpa_rsp_if
module rpa_back import rpa_pkg::*; #(
	parameter int PAGES      = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_out_t    head,
	output logic      pop,
	output logic      clearing,
	rpa_rsp_if.source rsp
);

	localparam int AW = $clog2(PAGES);
	localparam int TW = AW + 1;
	localparam logic [TW-1:0] TOP_MAX = TW'(PAGES);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CONE = COUNT_BITS'(1);

	typedef enum logic [2:0] {
		S_CLR = 3'b001,
		S_RD  = 3'b010,
		S_EX  = 3'b100
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;

	logic [COUNT_BITS-1:0] cnt_mem_q [PAGES];
	logic [PAGE_W-1:0]     lpool_q [PAGES];
	logic [PAGE_W-1:0]     hpool_q [PAGES];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [PAGE_W-1:0]     lp_rd_q;
	logic [PAGE_W-1:0]     hp_rd_q;
	logic [TW-1:0]         ltop_q;
	logic [TW-1:0]         htop_q;

	logic                  rsp_valid_q;
	logic [PAGE_W-1:0]     granted_q;
	status_t               status_q;
	logic [FREE_W-1:0]     low_free_q;
	logic [FREE_W-1:0]     high_free_q;

	logic [TW-1:0]         ltop_dec;
	logic [TW-1:0]         htop_dec;
	logic                  rd_en;
	logic                  out_free;
	logic                  commit;

	logic [TW-1:0]         ltop_n;
	logic [TW-1:0]         htop_n;
	logic [PAGE_W-1:0]     granted;
	status_t               st;
	logic                  ex_cnt_we;
	logic [AW-1:0]         ex_cnt_wa;
	logic [COUNT_BITS-1:0] ex_cnt_wd;
	logic                  ex_lp_we;
	logic                  ex_hp_we;

	logic                  cnt_we;
	logic [AW-1:0]         cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;

	assign clearing = state_q == S_CLR;
	assign ltop_dec = ltop_q - TW'(1);
	assign htop_dec = htop_q - TW'(1);
	assign rd_en    = (state_q == S_RD) && head.valid;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign commit   = (state_q == S_EX) && out_free;
	assign pop      = commit;

	always_comb begin
		ltop_n    = ltop_q;
		htop_n    = htop_q;
		granted   = '0;
		st        = ST_OK;
		ex_cnt_we = 1'b0;
		ex_cnt_wa = AW'(head.cmd.page);
		ex_cnt_wd = cnt_rd_q;
		ex_lp_we  = 1'b0;
		ex_hp_we  = 1'b0;
		case (head.cmd.kind)
			K_ALLOC: begin
				if (head.cmd.high_ok && htop_q != '0 && htop_q <= TOP_MAX) begin
					htop_n  = htop_dec;
					granted = hp_rd_q;
				end else if (ltop_q != '0 && ltop_q <= TOP_MAX) begin
					ltop_n  = ltop_dec;
					granted = lp_rd_q;
				end else begin
					st = ST_EMPTY;
				end
				ex_cnt_wa = AW'(granted);
				ex_cnt_wd = CONE;
				ex_cnt_we = (st == ST_OK) && (32'(granted) < 32'(PAGES));
			end
			K_RELEASE: begin
				if (head.cmd.pre != ST_OK) begin
					st = head.cmd.pre;
				end else if (cnt_rd_q == '0) begin
					st = ST_FREE;
				end else if (cnt_rd_q > CONE) begin
					ex_cnt_we = 1'b1;
					ex_cnt_wd = cnt_rd_q - CONE;
				end else if (head.cmd.low) begin
					if (ltop_q >= TOP_MAX) begin
						st = ST_RANGE;
					end else begin
						ex_lp_we  = 1'b1;
						ltop_n    = ltop_q + TW'(1);
						ex_cnt_we = 1'b1;
						ex_cnt_wd = '0;
					end
				end else begin
					if (htop_q >= TOP_MAX) begin
						st = ST_RANGE;
					end else begin
						ex_hp_we  = 1'b1;
						htop_n    = htop_q + TW'(1);
						ex_cnt_we = 1'b1;
						ex_cnt_wd = '0;
					end
				end
			end
			K_ADD: begin
				if (head.cmd.pre != ST_OK) begin
					st = head.cmd.pre;
				end else if (cnt_rd_q == CMAX) begin
					st = ST_SAT;
				end else begin
					ex_cnt_we = 1'b1;
					ex_cnt_wd = cnt_rd_q + CONE;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	always_comb begin
		if (clearing) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q;
			cnt_wd = CONE;
		end else begin
			cnt_we = commit && ex_cnt_we;
			cnt_wa = ex_cnt_wa;
			cnt_wd = ex_cnt_wd;
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem_q[cnt_wa] <= cnt_wd;
		if (rd_en)
			cnt_rd_q <= cnt_mem_q[AW'(head.cmd.page)];
	end

	// low stack
	always_ff @(posedge clk) begin
		if (commit && ex_lp_we)
			lpool_q[ltop_q[AW-1:0]] <= head.cmd.page;
		if (rd_en)
			lp_rd_q <= lpool_q[ltop_dec[AW-1:0]];
	end

	// high stack
	always_ff @(posedge clk) begin
		if (commit && ex_hp_we)
			hpool_q[htop_q[AW-1:0]] <= head.cmd.page;
		if (rd_en)
			hp_rd_q <= hpool_q[htop_dec[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(PAGES - 1))
						state_q <= S_RD;
				end
				S_RD: begin
					if (head.valid)
						state_q <= S_EX;
				end
				S_EX: begin
					if (out_free)
						state_q <= S_RD;
				end
				default: begin
					state_q <= S_CLR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ltop_q      <= '0;
			htop_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				ltop_q      <= ltop_n;
				htop_q      <= htop_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			granted_q   <= granted;
			status_q    <= st;
			low_free_q  <= FREE_W'(ltop_n);
			high_free_q <= FREE_W'(htop_n);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted_page = granted_q;
	assign rsp.status       = status_q;
	assign rsp.low_free     = low_free_q;
	assign rsp.high_free    = high_free_q;

endmodule

FILE: hw/rtl/refcounted_page_allocator.sv
// top level of the reference-counted page allocator
// depends on rpa_pkg, rpa_if, rpa_front, rpa_queue, rpa_back and the macro header
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, page_number, high_allowed
//   rsp      out  valid/ready    granted_page, status, low_free, high_free
//   cfg      in   cfg_we         cfg_index, cfg_wdata
//
// in the back end each request is handled in S_RD, which reads the count and stack
// memories, and then in S_EX, which updates them and loads the result register
// after reset a sweep over all PAGES entries sets every count to one; req.ready is low meanwhile
// a two-entry queue lets the front take requests while the result register waits
// on rsp.ready; the back end holds its update until that register is free
`include "refcounted_page_allocator_macros.svh"

module refcounted_page_allocator import rpa_pkg::*; #(
	parameter int PAGES      = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rpa_req_if.sink              req,
	rpa_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0] total_q;
	logic [CFG_W-1:0] bound_q;
	logic             clearing;
	logic             q_full;
	logic             pop;
	push_t            push;
	q_out_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
			bound_q <= BOUND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL: total_q <= cfg_wdata;
				CFG_BOUND: bound_q <= cfg_wdata;
				default: begin
					total_q <= total_q;
				end
			endcase
		end
	end

	rpa_front #(
		.PAGES(PAGES)
	) u_front (
		.req        (req),
		.clearing   (clearing),
		.q_full     (q_full),
		.page_total (total_q),
		.low_bound  (bound_q),
		.push       (push)
	);

	rpa_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.full  (q_full),
		.head  (head)
	);

	rpa_back #(
		.PAGES     (PAGES),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.clearing(clearing),
		.rsp     (rsp)
	);

	`RPA_ASSERT_IMP(a_no_req_in_sweep, clk, arst_n, clearing, !req.ready)
	`RPA_ASSERT_IMP(a_no_push_when_full, clk, arst_n, push.valid, !q_full || pop)
	`RPA_ASSERT_IMP(a_err_grants_zero, clk, arst_n, rsp.valid && rsp.status != ST_OK, rsp.granted_page == '0)
	`RPA_ASSERT_NXT(a_pop_spaced, clk, arst_n, pop, !pop)
	`RPA_ASSERT_IMP(a_pop_has_head, clk, arst_n, pop, head.valid)

endmodule

FILE: tb/sv/rpa_result_checker.sv
// result checker for the page allocator: tracks user counts and both free stacks,
// predicts one result per accepted request and compares it with the rsp channel
// depends on rpa_pkg and rpa_if
module rpa_result_checker import rpa_pkg::*; #(
	parameter int PAGES      = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rpa_req_if                   req,
	rpa_rsp_if                   rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   mismatches,
	output int                   pending,
	output int                   compared
);

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		status_t           status;
		logic [FREE_W-1:0] low_free;
		logic [FREE_W-1:0] high_free;
	} grant_t;

	logic [CFG_W-1:0]      page_limit;
	logic [CFG_W-1:0]      boundary;
	logic [COUNT_BITS-1:0] users [PAGES];
	logic [PAGE_W-1:0]     low_stack [PAGES];
	logic [PAGE_W-1:0]     high_stack [PAGES];
	logic [FREE_W-1:0]     low_depth;
	logic [FREE_W-1:0]     high_depth;
	grant_t                expected_grants [$];
	int                    fail_count;
	int                    seen_count;

	function automatic grant_t predict_grant(input kind_t kind, input logic [PAGE_W-1:0] pg,
			input logic high_ok);
		grant_t g;
		g = '0;
		g.status = ST_OK;
		case (kind)
			K_ALLOC: begin
				if (high_ok && high_depth != 0) begin
					high_depth = high_depth - 1'b1;
					g.page = high_stack[high_depth];
				end else if (low_depth != 0) begin
					low_depth = low_depth - 1'b1;
					g.page = low_stack[low_depth];
				end else begin
					g.status = ST_EMPTY;
				end
				if (g.status == ST_OK)
					users[g.page] = 1;
			end
			K_RELEASE: begin
				if (pg == 0) begin
					g.status = ST_ZERO;
				end else if (pg >= page_limit) begin
					g.status = ST_RANGE;
				end else if (users[pg] == 0) begin
					g.status = ST_FREE;
				end else if (users[pg] > 1) begin
					users[pg] = users[pg] - 1'b1;
				end else if (pg < boundary) begin
					if (low_depth >= PAGES) begin
						g.status = ST_RANGE;
					end else begin
						low_stack[low_depth] = pg;
						low_depth = low_depth + 1'b1;
						users[pg] = 0;
					end
				end else begin
					if (high_depth >= PAGES) begin
						g.status = ST_RANGE;
					end else begin
						high_stack[high_depth] = pg;
						high_depth = high_depth + 1'b1;
						users[pg] = 0;
					end
				end
			end
			K_ADD: begin
				if (pg >= page_limit)
					g.status = ST_RANGE;
				else if (users[pg] == COUNT_TOP)
					g.status = ST_SAT;
				else
					users[pg] = users[pg] + 1'b1;
			end
			default: ;
		endcase
		g.low_free = low_depth;
		g.high_free = high_depth;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		grant_t got;
		if (!arst_n) begin
			page_limit = TOTAL_RST;
			boundary = BOUND_RST;
			for (int i = 0; i < PAGES; i++)
				users[i] = 1;
			low_depth = '0;
			high_depth = '0;
			expected_grants.delete();
			fail_count = 0;
			seen_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.page = rsp.granted_page;
				got.status = status_t'(rsp.status);
				got.low_free = rsp.low_free;
				got.high_free = rsp.high_free;
				seen_count++;
				if (expected_grants.size() == 0) begin
					if (fail_count < 10)
						$display("result %0d arrived with nothing outstanding: page %0d status %0d",
							seen_count, got.page, got.status);
					fail_count++;
				end else begin
					want = expected_grants.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display({"result %0d mismatch: expected page %0d status %0d",
								" low %0d high %0d, got page %0d status %0d low %0d high %0d"},
								seen_count, want.page, want.status, want.low_free,
								want.high_free, got.page, got.status, got.low_free,
								got.high_free);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_grants.push_back(predict_grant(kind_t'(req.req_type), req.page_number,
					req.high_allowed));
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOTAL: page_limit = cfg_wdata;
					CFG_BOUND: boundary = cfg_wdata;
				endcase
			end
		end
		pending <= expected_grants.size();
		mismatches <= fail_count;
		compared <= seen_count;
	end

endmodule

FILE: tb/sv/tb.sv
// top of the page allocator testbench: clock, reset, request and register stimulus
// depends on rpa_pkg, rpa_if, refcounted_page_allocator and rpa_result_checker
module tb;
	import rpa_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 hold_rsp;
	int                   stall_pct;
	int                   send_idle_pct;
	int                   sent;
	int                   mismatches;
	int                   pending;
	int                   compared;

	rpa_req_if req ();
	rpa_rsp_if rsp ();

	refcounted_page_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	rpa_result_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp.ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_request(input kind_t kind, input logic [PAGE_W-1:0] pg,
			input logic high_ok);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.page_number <= pg;
		req.high_allowed <= high_ok;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_all_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
	endtask

	task automatic set_regs(input int total, input int bound);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOTAL;
		cfg_wdata <= CFG_W'(total);
		@(posedge clk);
		cfg_index <= CFG_BOUND;
		cfg_wdata <= CFG_W'(bound);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic hold_receiver(input int cycles);
		hold_rsp <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_rsp <= 1'b0;
	endtask

	task automatic random_requests(input int n, input int lo, input int hi);
		int    pick;
		kind_t kind;
		logic [PAGE_W-1:0] pg;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				kind = K_ALLOC;
			else if (pick < 70)
				kind = K_RELEASE;
			else if (pick < 93)
				kind = K_ADD;
			else
				kind = K_NOP;
			if ($urandom_range(0, 99) < 85)
				pg = PAGE_W'($urandom_range(lo, hi));
			else
				pg = PAGE_W'($urandom_range(0, 4095));
			send_request(kind, pg, 1'($urandom_range(0, 1)));
		end
	endtask

	// boot-style fill: free the range top down, then mix requests mostly over lo to hi+2
	task automatic run_setting(input int total, input int bound, input int lo, input int hi,
			input int n);
		int top_page;
		wait_all_results();
		set_regs(total, bound);
		for (int p = hi; p >= lo && p >= 1; p--)
			send_request(K_RELEASE, PAGE_W'(p), 1'b0);
		top_page = (hi + 2 > 4095) ? 4095 : hi + 2;
		random_requests(n, lo, top_page);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TOTAL;
		cfg_wdata = '0;
		hold_rsp = 1'b0;
		stall_pct = 0;
		send_idle_pct = 0;
		sent = 0;
		req.valid = 1'b0;
		req.req_type = K_ALLOC;
		req.page_number = '0;
		req.high_allowed = 1'b0;
		rsp.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty stacks, page zero, free page, fallback, range
		send_request(K_ALLOC, 12'd0, 1'b1);
		send_request(K_ALLOC, 12'd4095, 1'b0);
		send_request(K_RELEASE, 12'd0, 1'b1);
		send_request(K_NOP, 12'd4095, 1'b1);
		send_request(K_ADD, 12'd0, 1'b0);
		send_request(K_RELEASE, 12'd4095, 1'b0);
		send_request(K_RELEASE, 12'd4095, 1'b1);
		send_request(K_ADD, 12'd4095, 1'b0);
		send_request(K_RELEASE, 12'd1023, 1'b0);
		send_request(K_RELEASE, 12'd1024, 1'b0);
		send_request(K_RELEASE, 12'd1, 1'b0);
		send_request(K_ALLOC, 12'd0, 1'b1);
		send_request(K_ALLOC, 12'd0, 1'b0);
		send_request(K_ALLOC, 12'd0, 1'b1);
		send_request(K_ALLOC, 12'd0, 1'b1);
		send_request(K_ALLOC, 12'd0, 1'b1);
		wait_all_results();
		set_regs(1, 0);
		send_request(K_RELEASE, 12'd1, 1'b0);
		send_request(K_ADD, 12'd4095, 1'b1);
		send_request(K_ADD, 12'd1, 1'b0);
		send_request(K_RELEASE, 12'd0, 1'b0);
		send_request(K_ADD, 12'd0, 1'b1);
		send_request(K_NOP, 12'd0, 1'b0);

		run_setting(64, 16, 1, 63, 50);
		set_idling(85, 0);
		run_setting(40, 0, 1, 39, 50);
		set_idling(0, 85);
		wait_all_results();
		fork
			hold_receiver(400);
			run_setting(48, 4096, 1, 47, 50);
		join
		set_idling(19, 19);
		run_setting(4096, 4090, 4060, 4095, 50);
		run_setting(1, 1, 0, 3, 40);

		wait_all_results();
		repeat (10) @(posedge clk);
		$display("drove %0d requests over seven register settings, mixing allocate,", sent);
		$display("release and add under four idling mixes and a long hold; %0d results compared",
			compared);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
